[rtl/bdq_pkg.sv]
`default_nettype none

package bdq_pkg;

	// operation codes carried by each input item
	typedef enum logic [2:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_SIZE       = 3'd4,
		OP_EMPTY      = 3'd5,
		OP_FRONT      = 3'd6,
		OP_BACK       = 3'd7
	} opcode_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned FILL_W = 7;

endpackage

`default_nettype wire

[rtl/bdq_ram.sv]
`default_nettype none

module bdq_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                                    clk,
	input  wire logic                                    we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                        wdata,
	input  wire logic                                    re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// single write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/bounded_deque_engine_unit.sv]
`default_nettype none

// Bounded double-ended queue of signed 32-bit words kept as a ring buffer of
// DEPTH entries in one synchronous RAM, with a head pointer and an entry count
// in registers. Pushes, size and empty queries, pushes dropped on a full
// queue, and pops or peeks on an empty queue may be issued every cycle while
// no held result is waiting on out_ready. Pops and peeks on a non-empty queue
// read the entry from the RAM, whose read data is registered, and then load
// it into the result register; in_ready stays low during that read. The result
// register lets the next item be accepted in the same cycle that a waiting
// result is taken. The entry store needs no clearing after reset, so the
// block is ready at once.
module bounded_deque_engine_unit #(
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire bdq_pkg::opcode_t     opcode,
	input  wire logic signed [31:0]   push_value,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic signed [31:0]        data_value,
	output bdq_pkg::status_t          status,
	output logic [6:0]                fill_count
);

	import bdq_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned SW = AW + 1;

	// ring position of element k counted from the front
	function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
			input logic [CW-1:0] k);
		logic [SW-1:0] s;
		s = SW'(base) + SW'(k);
		if (s >= SW'(DEPTH)) begin
			s = s - SW'(DEPTH);
		end
		return s[AW-1:0];
	endfunction

	// count modulo 128 for the fill field
	function automatic logic [FILL_W-1:0] fill_of(input logic [CW-1:0] c);
		logic [CW+FILL_W-1:0] w;
		w = {{FILL_W{1'b0}}, c};
		return w[FILL_W-1:0];
	endfunction

	logic [AW-1:0]     head_q;
	logic [CW-1:0]     count_q;
	logic              busy_q;
	logic              out_valid_q;
	logic [DATA_W-1:0] out_data_q;
	status_t           out_status_q;
	logic [FILL_W-1:0] out_fill_q;

	logic              in_fire;
	logic              is_full;
	logic              is_empty;
	logic [AW-1:0]     head_inc;
	logic [AW-1:0]     head_dec;

	logic [AW-1:0]     head_d;
	logic [CW-1:0]     count_d;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [DATA_W-1:0] ram_rdata;
	logic              res_now;
	logic [DATA_W-1:0] res_data;
	status_t           res_status;

	assign in_ready = !busy_q && (!out_valid_q || out_ready);
	assign in_fire  = in_valid && in_ready;

	assign is_full  = (count_q == CW'(DEPTH));
	assign is_empty = (count_q == '0);
	assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
	assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);

	// decode of one operation against the current pointers
	always_comb begin
		head_d     = head_q;
		count_d    = count_q;
		ram_we     = 1'b0;
		ram_waddr  = head_q;
		ram_re     = 1'b0;
		ram_raddr  = head_q;
		res_now    = 1'b0;
		res_data   = '0;
		res_status = ST_OK;
		unique case (opcode)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (is_full) begin
					res_now    = 1'b1;
					res_status = ST_FULL;
				end else begin
					ram_we  = 1'b1;
					count_d = count_q + CW'(1);
					if (opcode == OP_PUSH_FRONT) begin
						head_d    = head_dec;
						ram_waddr = head_dec;
					end else begin
						ram_waddr = slot_of(head_q, count_q);
					end
				end
			end
			OP_POP_FRONT, OP_POP_BACK, OP_FRONT, OP_BACK: begin
				if (is_empty) begin
					res_now    = 1'b1;
					res_status = ST_EMPTY;
				end else begin
					ram_re = 1'b1;
					if (opcode == OP_POP_FRONT || opcode == OP_FRONT) begin
						ram_raddr = head_q;
					end else begin
						ram_raddr = slot_of(head_q, count_q - CW'(1));
					end
					if (opcode == OP_POP_FRONT) begin
						head_d  = head_inc;
						count_d = count_q - CW'(1);
					end else if (opcode == OP_POP_BACK) begin
						count_d = count_q - CW'(1);
					end
				end
			end
			OP_SIZE: begin
				res_now  = 1'b1;
				res_data = DATA_W'(count_q);
			end
			OP_EMPTY: begin
				res_now  = 1'b1;
				res_data = is_empty ? DATA_W'(1) : '0;
			end
		endcase
	end

	bdq_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (in_fire && ram_we),
		.waddr(ram_waddr),
		.wdata(push_value),
		.re   (in_fire && ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// pointers, read in flight and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				head_q  <= head_d;
				count_q <= count_d;
			end
			busy_q <= in_fire && ram_re;
			if (busy_q) begin
				out_valid_q <= 1'b1;
			end else if (in_fire) begin
				out_valid_q <= res_now;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (busy_q) begin
			out_data_q   <= ram_rdata;
			out_status_q <= ST_OK;
		end else if (in_fire) begin
			out_data_q   <= res_data;
			out_status_q <= res_status;
			out_fill_q   <= fill_of(count_d);
		end
	end

	assign out_valid  = out_valid_q;
	assign data_value = out_data_q;
	assign status     = out_status_q;
	assign fill_count = out_fill_q;

`ifndef NO_ASSERTIONS
	// count stays within the ring
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count beyond depth");

	// result register is free while a read is in flight
	a_busy_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !out_valid_q)
		else $error("read in flight with result still held");

	// read data always lands as a result
	a_busy_result: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |=> out_valid_q)
		else $error("read completed without a result");

	// an accepted push grows the count by one
	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && !is_full && (opcode == OP_PUSH_FRONT || opcode == OP_PUSH_BACK))
		|=> (count_q == $past(count_q) + CW'(1)))
		else $error("push did not grow the count");
`endif

endmodule

`default_nettype wire
